// File: hw/rtl/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int VALUE_W = 32;
    localparam int ENTRY_W = 32;
    localparam int POS_W   = 4;
    localparam int FILL_W  = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_READOUT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      found;
    } cell_ctrl_t;

    typedef struct packed {
        op_t                         op;
        logic signed [VALUE_W-1:0]   value;
    } req_item_t;

    typedef struct packed {
        status_t                     status;
        logic signed [ENTRY_W-1:0]   entry;
        logic [POS_W-1:0]            entry_pos;
        logic [FILL_W-1:0]           fill;
        logic                        last;
    } rsp_item_t;

endpackage

// File: hw/rtl/spq_cell.sv
module spq_cell #(
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  spq_pkg::cell_ctrl_t          ctrl,
    input  logic signed [DATA_WIDTH-1:0] key,
    input  logic                         occ,
    input  logic                         last_occ,
    input  logic signed [DATA_WIDTH-1:0] left_data,
    input  logic                         left_ge,
    input  logic signed [DATA_WIDTH-1:0] right_data,
    input  logic signed [DATA_WIDTH-1:0] head_data,
    output logic signed [DATA_WIDTH-1:0] data,
    output logic                         ge,
    output logic                         match
);
    import spq_pkg::*;

    logic signed [DATA_WIDTH-1:0] data_reg;
    logic signed [DATA_WIDTH-1:0] data_next;
    logic                         le;

    assign ge    = occ && (key >= data_reg);
    assign le    = occ && (data_reg <= key);
    assign match = occ && (data_reg == key);
    assign data  = data_reg;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            CELL_INSERT:
            begin
                if (left_ge)
                    data_next = left_data;
                else if (ge || !occ)
                    data_next = key;
            end
            CELL_DELETE:
            begin
                if (ctrl.found && le)
                    data_next = right_data;
            end
            CELL_ROTATE:
            begin
                if (last_occ)
                    data_next = head_data;
                else if (occ)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// File: hw/rtl/sorted_priority_queue_unit.sv
// results: insert, delete and unused codes give their single registered result in the cycle after acceptance
// throughput: one insert or delete per cycle while results are taken, set by the one-step compare-and-shift cell row
// read-out: first result registered after entering read-out state, then one result per cycle while taken;
//   input is held off while the row rotates each stored entry through cell 0
// reset: rst_n asynchronous active low clears the fill count, control state and output valid;
//   stored values are left as they are and only positions below the fill count are used
module sorted_priority_queue_unit #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = spq_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  spq_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output spq_pkg::rsp_item_t rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int VX = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int EX = (DATA_WIDTH > ENTRY_W) ? DATA_WIDTH : ENTRY_W;
    localparam int PX = (IW > POS_W) ? IW : POS_W;
    localparam int FX = (CW > FILL_W) ? CW : FILL_W;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   pos_reg, pos_next;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_item_t       rsp_reg, rsp_next;
    logic            rsp_load;
    logic            accept;
    logic            slot_free;
    logic            found;
    logic            read_last;
    cell_ctrl_t      ctrl;

    logic signed [VX-1:0]         value_ext;
    logic signed [DATA_WIDTH-1:0] key;
    logic signed [EX-1:0]         head_ext;
    logic [PX-1:0]                pos_ext;
    logic [FX-1:0]                fill_ext;

    logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]             cell_ge;
    logic [DEPTH-1:0]             cell_match;

    assign value_ext = VX'(req.value);
    assign key       = value_ext[DATA_WIDTH-1:0];
    assign head_ext  = EX'(cell_data[0]);
    assign pos_ext   = PX'(pos_reg);
    assign fill_ext  = FX'(count_next);

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && slot_free;
    assign accept    = req_valid && req_ready;
    assign found     = |cell_match;
    assign read_last = (CW'(pos_reg) + CW'(1)) == count_reg;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] left_data;
            logic signed [DATA_WIDTH-1:0] right_data;
            logic                         left_ge;

            if (i == 0)
            begin : g_head
                assign left_data = key;
                assign left_ge   = 1'b0;
            end
            else
            begin : g_body
                assign left_data = cell_data[i-1];
                assign left_ge   = cell_ge[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign right_data = cell_data[i];
            end
            else
            begin : g_inner
                assign right_data = cell_data[i+1];
            end

            spq_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .key        (key),
                .occ        (CW'(i) < count_reg),
                .last_occ   (CW'(i + 1) == count_reg),
                .left_data  (left_data),
                .left_ge    (left_ge),
                .right_data (right_data),
                .head_data  (cell_data[0]),
                .data       (cell_data[i]),
                .ge         (cell_ge[i]),
                .match      (cell_match[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        pos_next         = pos_reg;
        rsp_load         = 1'b0;
        ctrl.cmd         = CELL_HOLD;
        ctrl.found       = found;
        rsp_next.status  = STATUS_OK;
        rsp_next.entry   = '0;
        rsp_next.entry_pos = '0;
        rsp_next.last    = 1'b1;

        if (state_reg == ST_READOUT)
        begin
            if (slot_free)
            begin
                rsp_load           = 1'b1;
                ctrl.cmd           = CELL_ROTATE;
                rsp_next.entry     = head_ext[ENTRY_W-1:0];
                rsp_next.entry_pos = pos_ext[POS_W-1:0];
                rsp_next.last      = read_last;
                pos_next           = pos_reg + IW'(1);
                if (read_last)
                    state_next = ST_IDLE;
            end
        end
        else if (accept)
        begin
            rsp_load = 1'b1;
            case (req.op)
                OP_INSERT:
                begin
                    if (count_reg >= CW'(DEPTH))
                        rsp_next.status = STATUS_FULL;
                    else
                    begin
                        ctrl.cmd   = CELL_INSERT;
                        count_next = count_reg + CW'(1);
                    end
                end
                OP_DELETE:
                begin
                    if (count_reg == '0)
                        rsp_next.status = STATUS_EMPTY;
                    else if (!found)
                        rsp_next.status = STATUS_NOTFOUND;
                    else
                    begin
                        ctrl.cmd   = CELL_DELETE;
                        count_next = count_reg - CW'(1);
                    end
                end
                OP_READ:
                begin
                    if (count_reg == '0)
                        rsp_next.status = STATUS_EMPTY;
                    else
                    begin
                        rsp_load   = 1'b0;
                        pos_next   = '0;
                        state_next = ST_READOUT;
                    end
                end
                default:
                begin
                    rsp_next.status = STATUS_OK;
                end
            endcase
        end

        rsp_next.fill  = fill_ext[FILL_W-1:0];
        rsp_valid_next = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_count_hold_readout: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READOUT |=> $stable(count_reg))
        else $error("fill count changed during read-out");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.op == OP_INSERT && count_reg < CW'(DEPTH)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the store");

    a_pending_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.last |-> state_reg == ST_READOUT)
        else $error("non-final result outside read-out");

    a_last_ends_readout: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READOUT && rsp_load && read_last |=> state_reg == ST_IDLE)
        else $error("read-out did not end after final entry");

endmodule
